@@ sv/tcwe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwe_pkg
// Shared types and codes for the text console write engine.
// ----------------------------------------------------------------------------
package tcwe_pkg;

	typedef enum logic [2:0] {
		OP_READ,
		OP_PRINT,
		OP_LF,
		OP_CR,
		OP_TAB,
		OP_BS,
		OP_BELL,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        eow;
		logic [7:0]  chr;
		logic [13:0] rd_cell;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  idx;
		logic [7:0]  val;
		logic [15:0] data;
		logic        last;
	} res_t;

	localparam logic [15:0] BLANK_CELL = 16'h0720;
	localparam logic [15:0] CHAR_ATTR  = 16'h0700;
	localparam logic [15:0] BELL_CELL  = 16'h0201;

	localparam logic [3:0] CRTC_START_HI = 4'd12;
	localparam logic [3:0] CRTC_START_LO = 4'd13;
	localparam logic [3:0] CRTC_CURS_HI  = 4'd14;
	localparam logic [3:0] CRTC_CURS_LO  = 4'd15;

	localparam logic KIND_REG  = 1'b0;
	localparam logic KIND_CELL = 1'b1;

	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LO  = 8'h20;
	localparam logic [7:0] CH_HI  = 8'h7E;

endpackage

@@ sv/tcwe_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwe_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcwe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ sv/tcwe_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwe_front
// Accepts input words, classifies console bytes and queues commands.
// ----------------------------------------------------------------------------
module tcwe_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          enable,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [23:0]   s_axis_tdata,   // char_byte[7:0], read_cell[21:8]
	input  logic          s_axis_tuser,   // func
	input  logic          s_axis_tlast,   // end_of_write
	output tcwe_pkg::cmd_t cmd,
	output logic          cmd_valid,
	input  logic          cmd_pop
);
	import tcwe_pkg::*;

	cmd_t       q_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	cmd_t       in_cmd;
	logic       acc, push;

	always_comb begin
		in_cmd.eow     = s_axis_tlast;
		in_cmd.chr     = s_axis_tdata[7:0];
		in_cmd.rd_cell = s_axis_tdata[21:8];
		if (s_axis_tuser) in_cmd.op = OP_READ;
		else if (in_cmd.chr >= CH_LO && in_cmd.chr <= CH_HI) in_cmd.op = OP_PRINT;
		else if (in_cmd.chr == CH_LF) in_cmd.op = OP_LF;
		else if (in_cmd.chr == CH_CR) in_cmd.op = OP_CR;
		else if (in_cmd.chr == CH_TAB) in_cmd.op = OP_TAB;
		else if (in_cmd.chr == CH_BS) in_cmd.op = OP_BS;
		else if (in_cmd.chr == CH_BEL) in_cmd.op = OP_BELL;
		else in_cmd.op = OP_NONE;
	end

	assign s_axis_tready = enable && (cnt_q != 2'd2);
	assign acc  = s_axis_tvalid && s_axis_tready;
	// bytes with no effect and no cursor update are dropped here
	assign push = acc && !(in_cmd.op == OP_NONE && !in_cmd.eow);
	assign cmd       = q_q[rd_q];
	assign cmd_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (cmd_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule

@@ sv/tcwe_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwe_back
// Executes queued commands against video memory, scrolls, queues results.
// ----------------------------------------------------------------------------
module tcwe_back #(
	parameter int TEXT_COLUMNS = 80,
	parameter int TEXT_ROWS    = 25,
	parameter int MEMORY_CELLS = 16384
) (
	input  logic           clk,
	input  logic           arst_n,
	output logic           init_done,
	input  tcwe_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [31:0]    m_axis_tdata,  // reg_index[3:0], reg_value[11:4], cell_data[27:12]
	output logic           m_axis_tuser,  // kind
	output logic           m_axis_tlast   // last
);
	import tcwe_pkg::*;

	localparam int AW     = $clog2(MEMORY_CELLS);
	localparam int CW     = $clog2(TEXT_COLUMNS);
	localparam int RW     = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;
	localparam int NW     = AW + 1;
	localparam int SCREEN = TEXT_COLUMNS * TEXT_ROWS;
	localparam int COPY_N = TEXT_COLUMNS * (TEXT_ROWS - 1);
	localparam int FD     = 8;

	localparam logic [3:0] ST_INIT = 4'd0, ST_IDLE = 4'd1, ST_EXEC = 4'd2, ST_RDWAIT = 4'd3,
		ST_SCROLL = 4'd4, ST_COPY = 4'd5, ST_CLEAR = 4'd6, ST_E12 = 4'd7, ST_E13 = 4'd8,
		ST_E14 = 4'd9, ST_E15 = 4'd10;

	logic [3:0]    st_q;
	cmd_t          cur_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] origin_q;
	logic [NW-1:0] cnt_q;
	logic          wv_s1;
	logic [AW-1:0] waddr_s1;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [15:0]   wdata, rdata;

	res_t          fifo_q [FD];
	logic [2:0]    fwr_q, frd_q;
	logic [3:0]    fcnt_q;
	logic          fpush, fpop;
	res_t          fres;

	logic [AW-1:0] cur_addr;
	logic [CW:0]   col_inc, tab_col;
	logic [RW:0]   row_inc;
	logic          nl;
	logic [CW-1:0] col_nx;
	logic          fits;
	logic [15:0]   pos16, org16;

	assign cur_addr = AW'(32'(origin_q) + 32'(row_q) * TEXT_COLUMNS + 32'(col_q));
	assign col_inc  = {1'b0, col_q} + (CW+1)'(1);
	assign tab_col  = ({1'b0, col_q} | (CW+1)'(7)) + (CW+1)'(1);
	assign row_inc  = {1'b0, row_q} + (RW+1)'(1);
	assign fits     = (32'(origin_q) + 32'(SCREEN + TEXT_COLUMNS)) < 32'(MEMORY_CELLS);
	assign pos16    = 16'(cur_addr);
	assign org16    = 16'(origin_q);

	// cursor move for the current command
	always_comb begin
		nl     = 1'b0;
		col_nx = col_q;
		unique case (cur_q.op)
			OP_PRINT: begin
				if (col_inc >= (CW+1)'(TEXT_COLUMNS)) begin
					col_nx = '0;
					nl     = 1'b1;
				end else begin
					col_nx = col_inc[CW-1:0];
				end
			end
			OP_LF: begin
				col_nx = '0;
				nl     = 1'b1;
			end
			OP_CR: col_nx = '0;
			OP_TAB: begin
				if (tab_col >= (CW+1)'(TEXT_COLUMNS)) begin
					col_nx = '0;
					nl     = 1'b1;
				end else begin
					col_nx = tab_col[CW-1:0];
				end
			end
			OP_BS: begin
				if (col_q != '0) col_nx = col_q - CW'(1);
				else if (row_q != '0) col_nx = CW'(TEXT_COLUMNS - 1);
			end
			default: col_nx = col_q;
		endcase
	end

	// memory port selection
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = BLANK_CELL;
		raddr = AW'(cur_q.rd_cell);
		unique case (st_q)
			ST_INIT: begin
				we    = 1'b1;
				waddr = cnt_q[AW-1:0];
			end
			ST_EXEC: begin
				if (cur_q.op == OP_PRINT) begin
					we    = 1'b1;
					waddr = cur_addr;
					wdata = CHAR_ATTR + {8'h00, cur_q.chr};
				end else if (cur_q.op == OP_BELL) begin
					we    = 1'b1;
					waddr = AW'(32'(origin_q) + 32'(SCREEN - 1));
					wdata = BELL_CELL;
				end
			end
			ST_COPY: begin
				raddr = AW'(32'(origin_q) + 32'(TEXT_COLUMNS) + 32'(cnt_q));
				we    = wv_s1;
				waddr = waddr_s1;
				wdata = rdata;
			end
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = AW'(32'(origin_q) + 32'(SCREEN - TEXT_COLUMNS) + 32'(cnt_q));
			end
			default: we = 1'b0;
		endcase
	end

	tcwe_ram #(.WIDTH(16), .DEPTH(MEMORY_CELLS)) u_vram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// result words
	always_comb begin
		fpush     = 1'b0;
		fres.kind = KIND_REG;
		fres.idx  = CRTC_START_HI;
		fres.val  = org16[15:8];
		fres.data = '0;
		fres.last = 1'b0;
		unique case (st_q)
			ST_RDWAIT: begin
				fpush     = 1'b1;
				fres.kind = KIND_CELL;
				fres.idx  = '0;
				fres.val  = '0;
				fres.data = rdata;
				fres.last = 1'b1;
			end
			ST_E12: fpush = 1'b1;
			ST_E13: begin
				fpush     = 1'b1;
				fres.idx  = CRTC_START_LO;
				fres.val  = org16[7:0];
				fres.last = !cur_q.eow;
			end
			ST_E14: begin
				fpush    = 1'b1;
				fres.idx = CRTC_CURS_HI;
				fres.val = pos16[15:8];
			end
			ST_E15: begin
				fpush     = 1'b1;
				fres.idx  = CRTC_CURS_LO;
				fres.val  = pos16[7:0];
				fres.last = 1'b1;
			end
			default: fpush = 1'b0;
		endcase
	end

	assign init_done = (st_q != ST_INIT);
	// an item may leave up to four words, so start only with room for them
	assign cmd_pop   = (st_q == ST_IDLE) && cmd_valid && (fcnt_q <= 4'd4);

	always_ff @(posedge clk) begin
		if (cmd_pop) cur_q <= cmd;
		if (fpush) fifo_q[fwr_q] <= fres;
		if (st_q == ST_COPY) waddr_s1 <= cnt_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_INIT;
			col_q    <= '0;
			row_q    <= '0;
			origin_q <= '0;
			cnt_q    <= '0;
			wv_s1    <= 1'b0;
		end else begin
			unique case (st_q)
				ST_INIT: begin
					cnt_q <= cnt_q + NW'(1);
					if (cnt_q == NW'(MEMORY_CELLS - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: if (cmd_pop) st_q <= ST_EXEC;
				ST_EXEC: begin
					if (cur_q.op == OP_READ) begin
						st_q <= ST_RDWAIT;
					end else begin
						col_q <= col_nx;
						if (cur_q.op == OP_BS && col_q == '0 && row_q != '0)
							row_q <= row_q - RW'(1);
						if (nl && row_inc >= (RW+1)'(TEXT_ROWS)) begin
							st_q <= ST_SCROLL;
						end else begin
							if (nl) row_q <= row_inc[RW-1:0];
							st_q <= cur_q.eow ? ST_E14 : ST_IDLE;
						end
					end
				end
				ST_RDWAIT: st_q <= ST_IDLE;
				ST_SCROLL: begin
					cnt_q <= '0;
					wv_s1 <= 1'b0;
					if (fits) begin
						origin_q <= AW'(32'(origin_q) + 32'(TEXT_COLUMNS));
						st_q     <= ST_CLEAR;
					end else begin
						st_q <= ST_COPY;
					end
				end
				ST_COPY: begin
					// read one ahead, write the word read last cycle
					if (cnt_q < NW'(COPY_N)) begin
						cnt_q <= cnt_q + NW'(1);
						wv_s1 <= 1'b1;
					end else begin
						wv_s1 <= 1'b0;
						if (wv_s1) begin
							origin_q <= '0;
							cnt_q    <= '0;
							st_q     <= ST_CLEAR;
						end
					end
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + NW'(1);
					if (cnt_q == NW'(TEXT_COLUMNS - 1)) st_q <= ST_E12;
				end
				ST_E12: st_q <= ST_E13;
				ST_E13: st_q <= cur_q.eow ? ST_E14 : ST_IDLE;
				ST_E14: st_q <= ST_E15;
				ST_E15: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign fpop          = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = (fcnt_q != 4'd0);
	assign m_axis_tdata  = {4'h0, fifo_q[frd_q].data, fifo_q[frd_q].val, fifo_q[frd_q].idx};
	assign m_axis_tuser  = fifo_q[frd_q].kind;
	assign m_axis_tlast  = fifo_q[frd_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwr_q  <= '0;
			frd_q  <= '0;
			fcnt_q <= '0;
		end else begin
			if (fpush) fwr_q <= fwr_q + 3'd1;
			if (fpop) frd_q <= frd_q + 3'd1;
			fcnt_q <= fcnt_q + 4'(fpush) - 4'(fpop);
		end
	end

	a_col: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < TEXT_COLUMNS) else $error("cursor column out of line");
	a_row: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) < TEXT_ROWS) else $error("cursor row off screen");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(fpush && !fpop && fcnt_q == 4'(FD))) else $error("result queue overflow");
	a_org: assert property (@(posedge clk) disable iff (!arst_n)
		(origin_q != $past(origin_q)) |-> ($past(st_q) == ST_SCROLL || $past(st_q) == ST_COPY))
		else $error("origin moved outside a scroll");
endmodule

@@ sv/text_console_write_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_write_engine
// Console byte interpreter over a text-mode video memory with CRTC updates.
// ----------------------------------------------------------------------------
// Path: a readback word passes through the input queue, the command register, the
// registered video memory read and the result queue; cursor register words follow.
// Order: the back-end sequencer starts a command only from idle, once the last one
// is done and the result queue has room; the input queue holds two more. A scroll
// clears a new bottom row, first copying the lower rows to the start of memory if it does not fit.
// Reset: video RAM is cleared first, with no input accepted meanwhile.
module text_console_write_engine #(
	parameter int TEXT_COLUMNS = 80,
	parameter int TEXT_ROWS    = 25,
	parameter int MEMORY_CELLS = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // char_byte[7:0], read_cell[21:8]
	input  logic        s_axis_tuser,   // func
	input  logic        s_axis_tlast,   // end_of_write
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // reg_index[3:0], reg_value[11:4], cell_data[27:12]
	output logic        m_axis_tuser,   // kind
	output logic        m_axis_tlast    // last
);
	import tcwe_pkg::*;

	cmd_t cmd;
	logic cmd_valid, cmd_pop, init_done;

	tcwe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.enable        (init_done),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.cmd           (cmd),
		.cmd_valid     (cmd_valid),
		.cmd_pop       (cmd_pop)
	);

	tcwe_back #(
		.TEXT_COLUMNS (TEXT_COLUMNS),
		.TEXT_ROWS    (TEXT_ROWS),
		.MEMORY_CELLS (MEMORY_CELLS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.init_done     (init_done),
		.cmd           (cmd),
		.cmd_valid     (cmd_valid),
		.cmd_pop       (cmd_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);
endmodule
